// ----- rtl/mpm_pkg.sv -----
// ----------------------------------------------------------------------------
// mpm_pkg
// Shared types and codes for the multi-pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package mpm_pkg;

    // item kinds carried on the input tuser
    typedef enum logic [2:0] {
        MODE_PAT_LETTER  = 3'd0,
        MODE_PAT_END     = 3'd1,
        MODE_BUILD       = 3'd2,
        MODE_TEXT_LETTER = 3'd3,
        MODE_TEXT_END    = 3'd4
    } mode_t;

    localparam int SYMBOL_W = 5;
    localparam int PID_W    = 7;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 8;

    // controller states
    typedef enum logic [17:0] {
        ST_CLEAR  = 18'h00001,
        ST_IDLE   = 18'h00002,
        ST_PLET   = 18'h00004,
        ST_TLET   = 18'h00008,
        ST_B_R0   = 18'h00010,
        ST_B_W0   = 18'h00020,
        ST_B_POP  = 18'h00040,
        ST_B_GETU = 18'h00080,
        ST_B_GETF = 18'h00100,
        ST_B_RU   = 18'h00200,
        ST_B_RF   = 18'h00400,
        ST_B_WR   = 18'h00800,
        ST_E_RO   = 18'h01000,
        ST_E_RV   = 18'h02000,
        ST_E_WM   = 18'h04000,
        ST_E_SR   = 18'h08000,
        ST_E_SW   = 18'h10000,
        ST_E_EMIT = 18'h20000
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/multi_pattern_matcher.sv -----
// ----------------------------------------------------------------------------
// multi_pattern_matcher
// Aho-Corasick matcher: trie load, breadth-first build, text scan and report.
// ----------------------------------------------------------------------------
// channel  dir  tdata                          tuser      tlast
// s_       in   [4:0] symbol, [11:5] pat id    mode       -
// m_       out  [6:0] match_id, [7] overflow   found      last
//
// after reset a clearing pass writes every goto entry, with s_tready low
// pattern letter and text letter make one goto table read each; end pattern
// and ignored items are taken straight from idle
// build walks the trie breadth-first and is bound by the goto port
// end text spreads marks, collects ids and reports them; it waits on any
// m_tready stalls, and the output register lets results wait
`default_nettype none

module multi_pattern_matcher
    import mpm_pkg::*;
#(
    parameter int NODES        = 1024,
    parameter int ALPHABET     = 26,
    parameter int MAX_PATTERNS = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // symbol, pattern_id
    input  wire logic [2:0]          s_tuser,   // mode
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,   // match_id, overflow
    output logic                     m_tuser,   // found
    output logic                     m_tlast
);

    localparam int NW = $clog2(NODES);
    localparam int SW = $clog2(ALPHABET);
    localparam int KW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int GW = NW + SW;

    localparam logic [SW-1:0]   LAST_SYM = SW'(ALPHABET - 1);
    localparam logic [NW:0]     NODES_X  = (NW+1)'(NODES);
    localparam logic [PID_W-1:0] MAXP_ID = PID_W'(MAX_PATTERNS);

    // input fields
    logic [SYMBOL_W-1:0] symbol;
    logic [PID_W-1:0]    pattern_id;
    logic [2:0]          mode;
    logic                sym_ok;
    logic [SW-1:0]       sym;

    assign symbol     = s_tdata[SYMBOL_W-1:0];
    assign pattern_id = s_tdata[SYMBOL_W+PID_W-1:SYMBOL_W];
    assign mode       = s_tuser;
    assign sym_ok     = int'(symbol) < ALPHABET;
    assign sym        = SW'(symbol);

    // registers
    state_t                state_reg, state_next;
    logic [GW-1:0]         sweep_reg, sweep_next;
    logic [NW-1:0]         cursor_reg, cursor_next;
    logic [NW-1:0]         scan_reg, scan_next;
    logic [NW-1:0]         ncount_reg, ncount_next;
    logic                  built_reg, built_next;
    logic                  ovf_reg, ovf_next;
    logic                  drop_reg, drop_next;
    logic [NW:0]           head_reg, head_next;
    logic [NW:0]           tail_reg, tail_next;
    logic [NW:0]           idx_reg, idx_next;
    logic [NW-1:0]         n_reg, n_next;
    logic [NW-1:0]         u_reg, u_next;
    logic [NW-1:0]         f_reg, f_next;
    logic [NW-1:0]         v_reg, v_next;
    logic [SW-1:0]         let_reg, let_next;
    logic [MAX_PATTERNS-1:0] found_reg, found_next;
    logic [KW-1:0]         k_reg, k_next;
    logic                  mv_reg, mv_next;
    logic [PID_W-1:0]      mid_reg, mid_next;
    logic                  mfound_reg, mfound_next;
    logic                  mlast_reg, mlast_next;
    logic                  movf_reg, movf_next;

    // memory ports
    logic          g_we, f_we, p_we, o_we, mk_we;
    logic [GW-1:0] g_waddr, g_raddr;
    logic [NW-1:0] g_wdata, g_rdata;
    logic [NW-1:0] f_waddr, f_raddr, f_wdata, f_rdata;
    logic [NW-1:0] p_waddr, p_raddr;
    logic [PID_W-1:0] p_wdata, p_rdata;
    logic [NW-1:0] o_waddr, o_raddr, o_wdata, o_rdata;
    logic [NW-1:0] mk_waddr, mk_raddr;
    logic          mk_wdata, mk_rdata;

    logic          can_load;
    logic [PID_W-1:0] pid_m1;
    logic [MAX_PATTERNS-1:0] rest;

    assign can_load = !mv_reg || m_tready;
    assign pid_m1   = p_rdata - PID_W'(1);
    assign rest     = found_reg & ~(MAX_PATTERNS'(1) << k_reg);

    mpm_ram #(.ADDR_W(GW), .DATA_W(NW)) u_goto (
        .aclk(aclk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
        .raddr(g_raddr), .rdata(g_rdata)
    );
    mpm_ram #(.ADDR_W(NW), .DATA_W(NW)) u_fail (
        .aclk(aclk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );
    mpm_ram #(.ADDR_W(NW), .DATA_W(PID_W)) u_pat (
        .aclk(aclk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );
    mpm_ram #(.ADDR_W(NW), .DATA_W(NW)) u_order (
        .aclk(aclk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
        .raddr(o_raddr), .rdata(o_rdata)
    );
    mpm_ram #(.ADDR_W(NW), .DATA_W(1)) u_mark (
        .aclk(aclk), .we(mk_we), .waddr(mk_waddr), .wdata(mk_wdata),
        .raddr(mk_raddr), .rdata(mk_rdata)
    );

    assign s_tready = state_reg == ST_IDLE;

    // controller
    always_comb begin
        state_next  = state_reg;
        sweep_next  = sweep_reg;
        cursor_next = cursor_reg;
        scan_next   = scan_reg;
        ncount_next = ncount_reg;
        built_next  = built_reg;
        ovf_next    = ovf_reg;
        drop_next   = drop_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        idx_next    = idx_reg;
        n_next      = n_reg;
        u_next      = u_reg;
        f_next      = f_reg;
        v_next      = v_reg;
        let_next    = let_reg;
        found_next  = found_reg;
        k_next      = k_reg;
        mv_next     = mv_reg && !m_tready;
        mid_next    = mid_reg;
        mfound_next = mfound_reg;
        mlast_next  = mlast_reg;
        movf_next   = movf_reg;

        g_we = 1'b0; g_waddr = '0; g_wdata = '0; g_raddr = '0;
        f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
        p_we = 1'b0; p_waddr = '0; p_wdata = '0; p_raddr = '0;
        o_we = 1'b0; o_waddr = '0; o_wdata = '0; o_raddr = '0;
        mk_we = 1'b0; mk_waddr = '0; mk_wdata = 1'b0; mk_raddr = '0;

        case (state_reg)
            // zero the goto, failure, pattern and mark memories after reset
            ST_CLEAR: begin
                g_we    = 1'b1;
                g_waddr = sweep_reg;
                if (sweep_reg[SW-1:0] == '0) begin
                    f_we     = 1'b1;
                    f_waddr  = sweep_reg[GW-1:SW];
                    p_we     = 1'b1;
                    p_waddr  = sweep_reg[GW-1:SW];
                    mk_we    = 1'b1;
                    mk_waddr = sweep_reg[GW-1:SW];
                end
                sweep_next = sweep_reg + GW'(1);
                if (sweep_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            // dispatch one item
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (mode)
                        MODE_PAT_LETTER: begin
                            if (!built_reg && !drop_reg && sym_ok) begin
                                g_raddr    = {cursor_reg, sym};
                                let_next   = sym;
                                state_next = ST_PLET;
                            end
                        end
                        MODE_PAT_END: begin
                            if (!built_reg) begin
                                if (!drop_reg && cursor_reg != '0 &&
                                    pattern_id >= PID_W'(1) &&
                                    pattern_id <= MAXP_ID) begin
                                    p_we    = 1'b1;
                                    p_waddr = cursor_reg;
                                    p_wdata = pattern_id;
                                end
                                drop_next   = 1'b0;
                                cursor_next = '0;
                            end
                        end
                        MODE_BUILD: begin
                            if (!built_reg) begin
                                let_next   = '0;
                                head_next  = '0;
                                tail_next  = '0;
                                state_next = ST_B_R0;
                            end
                        end
                        MODE_TEXT_LETTER: begin
                            if (sym_ok) begin
                                g_raddr    = {scan_reg, sym};
                                state_next = ST_TLET;
                            end
                        end
                        MODE_TEXT_END: begin
                            idx_next   = tail_reg;
                            state_next = ST_E_RO;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // child lookup result for a pattern letter
            ST_PLET: begin
                if (g_rdata == '0) begin
                    if ((NW+1)'(ncount_reg) + (NW+1)'(1) >= NODES_X) begin
                        ovf_next  = 1'b1;
                        drop_next = 1'b1;
                    end else begin
                        ncount_next = ncount_reg + NW'(1);
                        g_we        = 1'b1;
                        g_waddr     = {cursor_reg, let_reg};
                        g_wdata     = ncount_reg + NW'(1);
                        cursor_next = ncount_reg + NW'(1);
                    end
                end else begin
                    cursor_next = g_rdata;
                end
                state_next = ST_IDLE;
            end
            // step the automaton and mark the node
            ST_TLET: begin
                scan_next  = g_rdata;
                mk_we      = 1'b1;
                mk_waddr   = g_rdata;
                mk_wdata   = 1'b1;
                state_next = ST_IDLE;
            end
            // root children seed the queue
            ST_B_R0: begin
                g_raddr    = {NW'(0), let_reg};
                state_next = ST_B_W0;
            end
            ST_B_W0: begin
                if (g_rdata != '0 && tail_reg < NODES_X) begin
                    o_we      = 1'b1;
                    o_waddr   = tail_reg[NW-1:0];
                    o_wdata   = g_rdata;
                    tail_next = tail_reg + (NW+1)'(1);
                end
                if (let_reg == LAST_SYM) begin
                    state_next = ST_B_POP;
                end else begin
                    let_next   = let_reg + SW'(1);
                    state_next = ST_B_R0;
                end
            end
            // pop the next node of the queue
            ST_B_POP: begin
                if (head_reg == tail_reg) begin
                    built_next = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    o_raddr    = head_reg[NW-1:0];
                    head_next  = head_reg + (NW+1)'(1);
                    state_next = ST_B_GETU;
                end
            end
            ST_B_GETU: begin
                u_next     = o_rdata;
                f_raddr    = o_rdata;
                state_next = ST_B_GETF;
            end
            ST_B_GETF: begin
                f_next     = f_rdata;
                let_next   = '0;
                state_next = ST_B_RU;
            end
            ST_B_RU: begin
                g_raddr    = {u_reg, let_reg};
                state_next = ST_B_RF;
            end
            ST_B_RF: begin
                v_next     = g_rdata;
                g_raddr    = {f_reg, let_reg};
                state_next = ST_B_WR;
            end
            // set failure link or fill the missing transition
            ST_B_WR: begin
                if (v_reg != '0) begin
                    f_we    = 1'b1;
                    f_waddr = v_reg;
                    f_wdata = g_rdata;
                    if (tail_reg < NODES_X) begin
                        o_we      = 1'b1;
                        o_waddr   = tail_reg[NW-1:0];
                        o_wdata   = v_reg;
                        tail_next = tail_reg + (NW+1)'(1);
                    end
                end else begin
                    g_we    = 1'b1;
                    g_waddr = {u_reg, let_reg};
                    g_wdata = g_rdata;
                end
                if (let_reg == LAST_SYM) begin
                    state_next = ST_B_POP;
                end else begin
                    let_next   = let_reg + SW'(1);
                    state_next = ST_B_RU;
                end
            end
            // spread marks along failure links, reverse order
            ST_E_RO: begin
                if (idx_reg == '0) begin
                    n_next     = '0;
                    state_next = ST_E_SR;
                end else begin
                    o_raddr    = idx_reg[NW-1:0] - NW'(1);
                    idx_next   = idx_reg - (NW+1)'(1);
                    state_next = ST_E_RV;
                end
            end
            ST_E_RV: begin
                mk_raddr   = o_rdata;
                f_raddr    = o_rdata;
                state_next = ST_E_WM;
            end
            ST_E_WM: begin
                if (mk_rdata) begin
                    mk_we    = 1'b1;
                    mk_waddr = f_rdata;
                    mk_wdata = 1'b1;
                end
                state_next = ST_E_RO;
            end
            // collect tagged ids of marked nodes and clear marks
            ST_E_SR: begin
                mk_raddr   = n_reg;
                p_raddr    = n_reg;
                state_next = ST_E_SW;
            end
            ST_E_SW: begin
                mk_we    = 1'b1;
                mk_waddr = n_reg;
                mk_wdata = 1'b0;
                if (mk_rdata && p_rdata >= PID_W'(1) && p_rdata <= MAXP_ID) begin
                    found_next[pid_m1[KW-1:0]] = 1'b1;
                end
                if (n_reg == ncount_reg) begin
                    k_next     = '0;
                    state_next = ST_E_EMIT;
                end else begin
                    n_next     = n_reg + NW'(1);
                    state_next = ST_E_SR;
                end
            end
            // report ids in ascending order, or one not-found item when none
            ST_E_EMIT: begin
                if (found_reg == '0) begin
                    if (can_load) begin
                        mv_next     = 1'b1;
                        mid_next    = '0;
                        mfound_next = 1'b0;
                        mlast_next  = 1'b1;
                        movf_next   = ovf_reg;
                        scan_next   = '0;
                        state_next  = ST_IDLE;
                    end
                end else if (found_reg[k_reg]) begin
                    if (can_load) begin
                        mv_next           = 1'b1;
                        mid_next          = PID_W'(k_reg) + PID_W'(1);
                        mfound_next       = 1'b1;
                        mlast_next        = rest == '0;
                        movf_next         = ovf_reg;
                        found_next[k_reg] = 1'b0;
                        k_next            = k_reg + KW'(1);
                        if (rest == '0) begin
                            scan_next  = '0;
                            state_next = ST_IDLE;
                        end
                    end
                end else begin
                    k_next = k_reg + KW'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            sweep_reg  <= '0;
            cursor_reg <= '0;
            scan_reg   <= '0;
            ncount_reg <= '0;
            built_reg  <= 1'b0;
            ovf_reg    <= 1'b0;
            drop_reg   <= 1'b0;
            tail_reg   <= '0;
            found_reg  <= '0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sweep_reg  <= sweep_next;
            cursor_reg <= cursor_next;
            scan_reg   <= scan_next;
            ncount_reg <= ncount_next;
            built_reg  <= built_next;
            ovf_reg    <= ovf_next;
            drop_reg   <= drop_next;
            tail_reg   <= tail_next;
            found_reg  <= found_next;
            mv_reg     <= mv_next;
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        head_reg   <= head_next;
        idx_reg    <= idx_next;
        n_reg      <= n_next;
        u_reg      <= u_next;
        f_reg      <= f_next;
        v_reg      <= v_next;
        let_reg    <= let_next;
        k_reg      <= k_next;
        mid_reg    <= mid_next;
        mfound_reg <= mfound_next;
        mlast_reg  <= mlast_next;
        movf_reg   <= movf_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {movf_reg, mid_reg};
    assign m_tuser  = mfound_reg;
    assign m_tlast  = mlast_reg;

    // checks
    a_cursor_in_trie: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg <= ncount_reg)
        else $error("insert cursor beyond allocated nodes");
    a_scan_in_trie: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> scan_reg <= ncount_reg)
        else $error("scan node beyond allocated nodes");
    a_no_result_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !mv_reg)
        else $error("result during clearing pass");
    a_found_empty_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> found_reg == '0)
        else $error("found ids left over after end of text");

endmodule

`default_nettype wire

// ----- rtl/mpm_ram.sv -----
// ----------------------------------------------------------------------------
// mpm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mpm_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 10
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-pattern matcher. A scoreboard class keeps
// its own trie, failure links and visit marks, predicts the ids reported at
// every end of text and checks each output item against them. The stimulus
// loads a pattern set, scans texts before and after the build, and then sends
// random texts under bursty input and a stalling output.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import mpm_pkg::*;

    localparam int NODES        = 1024;
    localparam int ALPHABET     = 26;
    localparam int MAX_PATTERNS = 64;

    typedef struct packed {
        logic [6:0] match_id;
        logic       found;
        logic       last;
        logic       overflow;
    } match_rec_t;

    // scoreboard: own copy of the automaton plus the queue of pending reports
    class match_board;
        int unsigned goto_next [NODES][ALPHABET];
        int unsigned fail_link [NODES];
        int unsigned node_tag [NODES];
        int unsigned visit_order [NODES];
        bit          seen [NODES];
        int unsigned node_total, cursor, scan_at, order_total;
        bit          built, overflowed, dropping;
        match_rec_t  expected_q [$];
        int          errors;
        int          results_checked;
        int          texts_done;

        function new();
            foreach (goto_next[i, j]) goto_next[i][j] = 0;
            foreach (fail_link[i]) begin
                fail_link[i] = 0;
                node_tag[i]  = 0;
                seen[i]      = 0;
            end
            node_total = 0; cursor = 0; scan_at = 0; order_total = 0;
            built = 0; overflowed = 0; dropping = 0;
            errors = 0; results_checked = 0; texts_done = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // breadth-first pass: failure links, completed goto table, order
        function void build_links();
            int unsigned head, tail, u, f, v;
            head = 0;
            tail = 0;
            for (int c = 0; c < ALPHABET; c++) begin
                v = goto_next[0][c];
                if (v != 0 && tail < NODES) begin
                    fail_link[v] = 0;
                    visit_order[tail] = v;
                    tail++;
                end
            end
            while (head < tail) begin
                u = visit_order[head];
                head++;
                f = fail_link[u];
                for (int c = 0; c < ALPHABET; c++) begin
                    v = goto_next[u][c];
                    if (v != 0) begin
                        fail_link[v] = goto_next[f][c];
                        if (tail < NODES) begin
                            visit_order[tail] = v;
                            tail++;
                        end
                    end else begin
                        goto_next[u][c] = goto_next[f][c];
                    end
                end
            end
            order_total = tail;
            built = 1;
        endfunction

        // spread marks, collect ids, queue the reports of one text
        function void close_text();
            bit [MAX_PATTERNS-1:0] hits;
            int unsigned v, id;
            match_rec_t r;
            int n;
            hits = '0;
            n = 0;
            for (int i = order_total; i > 0; i--) begin
                v = visit_order[i-1];
                if (seen[v]) seen[fail_link[v]] = 1;
            end
            for (int i = 1; i <= node_total && i < NODES; i++) begin
                id = node_tag[i];
                if (seen[i] && id >= 1 && id <= MAX_PATTERNS) hits[id-1] = 1;
            end
            for (int i = 1; i <= MAX_PATTERNS; i++) begin
                if (hits[i-1]) begin
                    n++;
                    r.match_id = 7'(i);
                    r.found    = 1'b1;
                    r.last     = (hits >> i) == 0;
                    r.overflow = overflowed;
                    expected_q = {expected_q, r};
                end
            end
            if (n == 0) begin
                r.match_id = '0;
                r.found    = 1'b0;
                r.last     = 1'b1;
                r.overflow = overflowed;
                expected_q = {expected_q, r};
            end
            foreach (seen[i]) seen[i] = 0;
            scan_at = 0;
            texts_done++;
        endfunction

        // accepted input item
        function void note_item(logic [2:0] mode, logic [4:0] sym, logic [6:0] pid);
            case (mode)
                MODE_PAT_LETTER: begin
                    if (!built && !dropping && sym < ALPHABET) begin
                        if (goto_next[cursor][sym] == 0) begin
                            if (node_total + 1 >= NODES) begin
                                overflowed = 1;
                                dropping   = 1;
                            end else begin
                                node_total++;
                                goto_next[cursor][sym] = node_total;
                            end
                        end
                        if (!dropping) cursor = goto_next[cursor][sym];
                    end
                end
                MODE_PAT_END: begin
                    if (!built) begin
                        if (!dropping && cursor != 0 &&
                            pid >= 1 && pid <= MAX_PATTERNS)
                            node_tag[cursor] = pid;
                        dropping = 0;
                        cursor   = 0;
                    end
                end
                MODE_BUILD: begin
                    if (!built) build_links();
                end
                MODE_TEXT_LETTER: begin
                    if (sym < ALPHABET) begin
                        scan_at = goto_next[scan_at][sym];
                        seen[scan_at] = 1;
                    end
                end
                MODE_TEXT_END: close_text();
                default: ;
            endcase
        endfunction

        function void flag_error(string what, match_rec_t e, match_rec_t a);
            errors++;
            if (errors <= 10)
                $display({"[%0t] %s: expected id=%0d found=%0b last=%0b ovf=%0b, ",
                          "got id=%0d found=%0b last=%0b ovf=%0b"},
                         $time, what, e.match_id, e.found, e.last, e.overflow,
                         a.match_id, a.found, a.last, a.overflow);
        endfunction

        // accepted output item against the oldest expectation
        function void check_result(match_rec_t got);
            match_rec_t want;
            results_checked++;
            if (expected_q.size() == 0) begin
                flag_error("report with nothing pending", '0, got);
                return;
            end
            want = expected_q.pop_front();
            if (want.match_id !== got.match_id) flag_error("match_id differs", want, got);
            else if (want.found !== got.found) flag_error("found differs", want, got);
            else if (want.last !== got.last) flag_error("last differs", want, got);
            else if (want.overflow !== got.overflow) flag_error("overflow differs", want, got);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // [4:0] symbol, [11:5] pattern_id
    logic [2:0]  s_tuser;    // mode
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // [6:0] match_id, [7] overflow
    logic        m_tuser;    // found
    logic        m_tlast;

    match_board board;
    int         burst_left;
    bit         hold_req;
    int         matches_seen;

    multi_pattern_matcher uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // input side monitor
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            board.note_item(s_tuser, s_tdata[4:0], s_tdata[11:5]);
    end

    // output side monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result({m_tdata[6:0], m_tuser, m_tlast, m_tdata[7]});
            if (m_tuser) matches_seen++;
        end
    end

    // receiver: stall segments of random kind, plus one long hold on request
    initial begin
        int seg_left;
        int seg_kind;
        int hold_cycles;
        seg_left = 0;
        seg_kind = 0;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                hold_cycles = 0;
                while (hold_cycles < 800) begin
                    @(posedge aclk);
                    hold_cycles++;
                end
                hold_req = 0;
            end else begin
                if (seg_left == 0) begin
                    seg_kind = $urandom_range(0, 2);
                    seg_left = $urandom_range(20, 200);
                end
                seg_left--;
                case (seg_kind)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ($urandom_range(0, 9) < 3);
                endcase
                @(posedge aclk);
            end
        end
    end

    // one input item, offered in bursts with random gaps
    task automatic send_item(input logic [2:0] mode, input logic [4:0] sym,
                             input logic [6:0] pid);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'b0, pid, sym};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    // sender pause until every pending report has come back
    task automatic drain(input int settle);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic send_word(input int len, input int top_letter, input logic [6:0] pid);
        for (int i = 0; i < len; i++)
            send_item(MODE_PAT_LETTER, 5'($urandom_range(0, top_letter)), 7'($urandom));
        send_item(MODE_PAT_END, 5'($urandom), pid);
    endtask

    // text letters: mostly the pattern alphabet, some others and the filler letter
    function automatic logic [4:0] text_letter();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return 5'($urandom_range(0, 4));
        if (r < 96) return 5'($urandom_range(5, 24));
        return 5'd25;
    endfunction

    task automatic send_text(input int len);
        for (int i = 0; i < len; i++)
            send_item(MODE_TEXT_LETTER, text_letter(), 7'($urandom));
        send_item(MODE_TEXT_END, 5'($urandom), 7'($urandom));
    endtask

    // stimulus
    initial begin
        int sent;
        int r;
        bit held;
        bit paused;
        board        = new();
        burst_left   = 0;
        hold_req     = 0;
        matches_seen = 0;
        held     = 0;
        paused   = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed loading: edge ids, shared and repeated words, dropped letter
        send_item(MODE_PAT_LETTER, 5'd0, 7'h7f);
        send_item(MODE_PAT_END, 5'd31, 7'd1);
        send_item(MODE_PAT_LETTER, 5'd0, 7'd0);
        send_item(MODE_PAT_LETTER, 5'd1, 7'd0);
        send_item(MODE_PAT_END, 5'd0, 7'd64);
        send_item(MODE_PAT_LETTER, 5'd2, 7'd0);
        send_item(MODE_PAT_LETTER, 5'd3, 7'd0);
        send_item(MODE_PAT_END, 5'd0, 7'd12);
        send_item(MODE_PAT_LETTER, 5'd2, 7'd0);
        send_item(MODE_PAT_LETTER, 5'd3, 7'd0);
        send_item(MODE_PAT_END, 5'd0, 7'd13);
        send_item(MODE_PAT_LETTER, 5'd3, 7'd0);
        send_item(MODE_PAT_LETTER, 5'd31, 7'd0);
        send_item(MODE_PAT_LETTER, 5'd26, 7'd0);
        send_item(MODE_PAT_LETTER, 5'd4, 7'd0);
        send_item(MODE_PAT_END, 5'd0, 7'd12);
        send_item(MODE_PAT_END, 5'd0, 7'd5);
        send_item(MODE_PAT_LETTER, 5'd1, 7'd0);
        send_item(MODE_PAT_LETTER, 5'd2, 7'd0);
        send_item(MODE_PAT_END, 5'd0, 7'd0);
        send_item(MODE_PAT_LETTER, 5'd2, 7'd0);
        send_item(MODE_PAT_END, 5'd0, 7'd65);
        send_item(MODE_PAT_LETTER, 5'd4, 7'd0);
        send_item(MODE_PAT_END, 5'd0, 7'd127);
        for (int i = 0; i < 18; i++)
            send_word($urandom_range(1, 4), 4, 7'($urandom_range(1, MAX_PATTERNS)));

        // texts on the bare trie, an empty text, unused modes
        send_text(6);
        send_item(MODE_TEXT_END, 5'd0, 7'd0);
        send_item(3'd5, 5'd31, 7'h7f);
        send_item(3'd6, 5'd0, 7'd0);
        send_item(3'd7, 5'd31, 7'h7f);
        send_text(4);
        drain(50);

        // a few more words with the filler letter
        send_item(MODE_PAT_LETTER, 5'd25, 7'd0);
        send_item(MODE_PAT_END, 5'd0, 7'd30);
        send_item(MODE_PAT_LETTER, 5'd25, 7'd0);
        send_item(MODE_PAT_LETTER, 5'd16, 7'd0);
        send_item(MODE_PAT_END, 5'd0, 7'd31);

        // build twice, loading after build is ignored
        send_item(MODE_BUILD, 5'd0, 7'd0);
        send_item(MODE_BUILD, 5'd31, 7'h7f);
        send_item(MODE_PAT_LETTER, 5'd0, 7'd0);
        send_item(MODE_PAT_END, 5'd0, 7'd9);
        send_text(8);
        send_item(MODE_TEXT_END, 5'd0, 7'd0);
        drain(50);

        // random texts with some noise, one long receiver hold on the way
        sent = 0;
        while (sent < 110) begin
            if (!held && sent >= 40) begin
                held = 1;
                hold_req = 1;
                for (int i = 0; i < 6; i++) send_text($urandom_range(0, 3));
                sent += 18;
            end
            r = $urandom_range(0, 9);
            if (r < 8) begin
                int len;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30)
                                                  : $urandom_range(0, 12);
                send_text(len);
                sent += len + 1;
            end else begin
                case ($urandom_range(0, 4))
                    0: send_item(3'($urandom_range(5, 7)), 5'($urandom), 7'($urandom));
                    1: send_item(MODE_TEXT_LETTER, 5'($urandom_range(26, 31)), 7'($urandom));
                    2: send_item(MODE_PAT_LETTER, 5'($urandom), 7'($urandom));
                    3: send_item(MODE_PAT_END, 5'($urandom), 7'($urandom));
                    default: send_item(MODE_BUILD, 5'($urandom), 7'($urandom));
                endcase
                sent++;
            end
            if (!paused && sent >= 80) begin
                paused = 1;
                drain(20);
            end
        end

        drain(200);
        $display("covered %0d texts, %0d reports checked, %0d of them matches",
                 board.texts_done, board.results_checked, matches_seen);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d reports missing", board.errors, board.pending());
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("timeout with %0d reports pending", board.pending());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/mpm_pkg.sv
rtl/mpm_ram.sv
rtl/multi_pattern_matcher.sv
tb/tb_top.sv
